// ===== hdl/vdib_pkg.sv =====
// ----------------------------------------------------------------------------
// vdib_pkg
// Shared types and constants for the vertex dedup index builder.
// ----------------------------------------------------------------------------
package vdib_pkg;
    localparam int TableDepth = 256;
    localparam int WordsPerVertex = 8;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] normal_x;
        logic [31:0] normal_y;
        logic [31:0] normal_z;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
    } t_vertex;

    typedef struct packed {
        logic [7:0] vertex_index;
        logic       was_new;
        logic       overflow;
    } t_result;

    // search token walking down the row of cells
    typedef struct packed {
        logic            valid;
        logic            found;
        logic [IdxW-1:0] hit_idx;
    } t_token;

    function automatic logic word_equal(input logic [31:0] a, input logic [31:0] b);
        logic [30:0] ma;
        logic [30:0] mb;
        ma = a[30:0];
        mb = b[30:0];
        if (ma > 31'h7F800000 || mb > 31'h7F800000) return 1'b0;
        if (ma == 31'd0 && mb == 31'd0) return 1'b1;
        return a == b;
    endfunction

    function automatic logic vertex_equal(input t_vertex a, input t_vertex b);
        return word_equal(a.pos_x, b.pos_x) && word_equal(a.pos_y, b.pos_y)
            && word_equal(a.pos_z, b.pos_z) && word_equal(a.normal_x, b.normal_x)
            && word_equal(a.normal_y, b.normal_y) && word_equal(a.normal_z, b.normal_z)
            && word_equal(a.tex_u, b.tex_u) && word_equal(a.tex_v, b.tex_v);
    endfunction
endpackage

// ===== hdl/vdib_cell.sv =====
// ----------------------------------------------------------------------------
// vdib_cell
// One table entry: holds a stored vertex, compares the passing query and
// forwards query and search token to the next cell.
// ----------------------------------------------------------------------------
module vdib_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [vdib_pkg::IdxW-1:0] i_my_idx,
    input  vdib_pkg::t_vertex       i_query,
    input  vdib_pkg::t_token        i_token,
    input  logic                    i_wr,
    input  logic                    i_live,
    output vdib_pkg::t_vertex       o_query,
    output vdib_pkg::t_token        o_token
);
    vdib_pkg::t_vertex r_entry;
    vdib_pkg::t_vertex r_query;
    vdib_pkg::t_token  r_token;
    logic              w_hit;

    assign w_hit = i_live && vdib_pkg::vertex_equal(r_entry, i_query);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_entry <= i_query;
        end
        r_query <= i_query;
        if (!i_rst_n) begin
            r_token <= '0;
        end else begin
            r_token.valid <= i_token.valid;
            if (i_token.valid && !i_token.found && w_hit) begin
                r_token.found   <= 1'b1;
                r_token.hit_idx <= i_my_idx;
            end else begin
                r_token.found   <= i_token.found;
                r_token.hit_idx <= i_token.hit_idx;
            end
        end
    end

    assign o_query = r_query;
    assign o_token = r_token;
endmodule

// ===== hdl/vertex_dedup_index_builder.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_index_builder
// Vertex dedup table as a systolic row of compare cells.
// One vertex is in flight at a time: start is ignored while busy, and the
// query walks the whole cell row, one cell per cycle, before busy drops.
// Reset (synchronous, active low) empties the table; no clearing pass.
// The receiver cannot stall: o_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module vertex_dedup_index_builder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  vdib_pkg::t_vertex i_vertex,
    output logic              o_valid,
    output vdib_pkg::t_result o_result
);
    localparam int N = vdib_pkg::TableDepth;

    vdib_pkg::t_vertex q [N+1];
    vdib_pkg::t_token  t [N+1];

    logic [vdib_pkg::CntW-1:0] r_count;
    logic                      r_busy;
    logic                      r_valid;
    vdib_pkg::t_result         r_result;
    vdib_pkg::t_vertex         r_query;
    logic                      r_go;

    assign q[0] = r_query;
    assign t[0] = '{valid: r_go, found: 1'b0, hit_idx: '0};

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic w_wr;
            assign w_wr = t[N].valid && !t[N].found
                && (r_count == vdib_pkg::CntW'(g));
            vdib_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_my_idx(vdib_pkg::IdxW'(g)),
                .i_query (q[g]),
                .i_token (t[g]),
                .i_wr    (w_wr),
                .i_live  (r_count > vdib_pkg::CntW'(g)),
                .o_query (q[g+1]),
                .o_token (t[g+1])
            );
        end
    endgenerate

    // q[N] equals r_query at the end; cell writes use its own q[g] which
    // also equals r_query since the query is held stable while busy.

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_query <= i_vertex;
        end
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_go    <= start && !r_busy;
            r_valid <= 1'b0;
            if (start && !r_busy) begin
                r_busy <= 1'b1;
            end
            if (t[N].valid) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
                if (t[N].found) begin
                    r_result <= '{vertex_index: 8'(t[N].hit_idx), was_new: 1'b0,
                                  overflow: 1'b0};
                end else if (r_count < vdib_pkg::CntW'(N)) begin
                    r_result <= '{vertex_index: 8'(r_count), was_new: 1'b1,
                                  overflow: 1'b0};
                    r_count  <= r_count + 1'b1;
                end else begin
                    r_result <= '{vertex_index: 8'd0, was_new: 1'b0, overflow: 1'b1};
                end
            end
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule
